>>> src/forward_star_graph_store_unit_assert.svh
// Assertion macros for the graph store.
`ifndef FORWARD_STAR_GRAPH_STORE_UNIT_ASSERT_SVH
`define FORWARD_STAR_GRAPH_STORE_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define FSG_ASSERT_IMPL(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence at the next edge.
`define FSG_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/fsg_pkg.sv
`timescale 1ns / 1ps
package fsg_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxArcs     = 64;
    localparam int VidW        = $clog2(MaxVertices);
    localparam int AidW        = $clog2(MaxArcs);
    localparam int VcntW       = VidW + 1;
    localparam int AcntW       = AidW + 1;
    localparam int WeightW     = 16;
    localparam int PayloadW    = 32;
    localparam int ResultCap   = 64;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_ADD_V  = 3'd1;
    localparam logic [2:0] OP_ADD_A  = 3'd2;
    localparam logic [2:0] OP_LIST   = 3'd3;
    localparam logic [2:0] OP_READ_W = 3'd4;
    localparam logic [2:0] OP_WRITE_W = 3'd5;
    localparam logic [2:0] OP_READ_V = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NOT_FND = 3'd2;
    localparam logic [2:0] ST_BAD_ID  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic REG_VERTEX_LIMIT = 1'b0;
    localparam logic REG_ARC_LIMIT    = 1'b1;

    typedef struct packed {
        logic [2:0]          operation;
        logic [VidW-1:0]     from_vertex;
        logic [VidW-1:0]     to_vertex;
        logic [WeightW-1:0]  arc_weight;
        logic [PayloadW-1:0] vertex_payload;
    } cmd_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [VidW-1:0]     neighbor_id;
        logic [WeightW-1:0]  weight_out;
        logic [PayloadW-1:0] payload_out;
        logic [VidW-1:0]     new_vertex_id;
        logic [VcntW-1:0]    vertex_total;
        logic                last;
    } result_t;
endpackage

>>> src/fsg_cmd_queue.sv
`timescale 1ns / 1ps
module fsg_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fsg_pkg::cmd_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output fsg_pkg::cmd_t head
);
    import fsg_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];
endmodule

>>> src/fsg_engine.sv
`timescale 1ns / 1ps
module fsg_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  fsg_pkg::cmd_t            cmd,
    output logic                     cmd_pop,
    input  logic [fsg_pkg::VcntW-1:0] vlim,
    input  logic [fsg_pkg::AcntW-1:0] alim,
    output logic                     res_strobe,
    output fsg_pkg::result_t         res,
    output logic                     idle
);
    import fsg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_EXAM = 3'd5;

    logic [AidW:0]     head_mem [MaxVertices];
    logic [VidW-1:0]   tgt_mem  [MaxArcs];
    logic [WeightW-1:0] wgt_mem [MaxArcs];
    logic [AidW:0]     link_mem [MaxArcs];
    logic [PayloadW-1:0] pay_mem [MaxVertices];

    logic [MaxVertices-1:0] head_vld_reg, head_vld_next;
    logic [2:0]        state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [VcntW-1:0]  vtot_reg, vtot_next;
    logic [AcntW-1:0]  atot_reg, atot_next;
    logic [AidW:0]     idx_reg, idx_next;
    logic [AcntW-1:0]  cnt_reg, cnt_next;
    logic [AidW:0]     head_q, link_q;
    logic [VidW-1:0]   tgt_q;
    logic [WeightW-1:0] wgt_q;
    logic [PayloadW-1:0] pay_q;
    logic              res_strobe_reg, res_strobe_next;
    result_t           res_reg, res_next;

    logic src_ok, dst_ok, walk_end, chain_end, is_read;
    logic pay_we, arc_we, head_we, wgt_we;
    logic [AidW-1:0] wgt_addr;
    logic [AidW:0] head_rd;

    assign src_ok   = {1'b0, cur_reg.from_vertex} < vtot_reg;
    assign dst_ok   = {1'b0, cur_reg.to_vertex} < vtot_reg;
    assign is_read  = cur_reg.operation == OP_READ_W;
    assign head_rd  = head_vld_reg[cur_reg.from_vertex] ? head_q : (AidW+1)'(MaxArcs);
    assign walk_end = !(link_q < atot_reg) || (cnt_reg + 1'b1 >= AcntW'(ResultCap));
    assign chain_end = !(link_q < atot_reg) || (cnt_reg + 1'b1 >= AcntW'(MaxArcs));
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign idle     = (state_reg == S_IDLE) && !res_strobe_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        vtot_next       = vtot_reg;
        atot_next       = atot_reg;
        head_vld_next   = head_vld_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_strobe_next = 1'b0;
        res_next        = '{status: ST_OK, neighbor_id: '0, weight_out: '0,
                            payload_out: '0, new_vertex_id: '0,
                            vertex_total: vtot_reg, last: 1'b1};
        pay_we   = 1'b0;
        arc_we   = 1'b0;
        head_we  = 1'b0;
        wgt_we   = 1'b0;
        wgt_addr = atot_reg[AidW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
                // Wait for the registered head and payload reads.
                state_next = S_READ;
            S_READ:
            begin
                state_next      = S_DONE;
                res_strobe_next = 1'b1;
                idx_next        = head_rd;
                cnt_next        = '0;
                unique case (cur_reg.operation)
                    OP_CLEAR:
                    begin
                        vtot_next = '0;
                        atot_next = '0;
                        head_vld_next = '0;
                        res_next.vertex_total = '0;
                    end
                    OP_ADD_V:
                    begin
                        if (vtot_reg >= vlim)
                            res_next.status = ST_FULL;
                        else
                        begin
                            pay_we = 1'b1;
                            head_vld_next[vtot_reg[VidW-1:0]] = 1'b0;
                            vtot_next = vtot_reg + 1'b1;
                            res_next.new_vertex_id = vtot_reg[VidW-1:0];
                            res_next.vertex_total = vtot_reg + 1'b1;
                        end
                    end
                    OP_ADD_A:
                    begin
                        if (atot_reg >= alim)
                            res_next.status = ST_FULL;
                        else if (!src_ok || !dst_ok)
                            res_next.status = ST_BAD_ID;
                        else
                        begin
                            arc_we  = 1'b1;
                            wgt_we  = 1'b1;
                            head_we = 1'b1;
                            head_vld_next[cur_reg.from_vertex] = 1'b1;
                            atot_next = atot_reg + 1'b1;
                        end
                    end
                    OP_LIST:
                    begin
                        if (!src_ok)
                            res_next.status = ST_BAD_ID;
                        else if (!(head_rd < atot_reg))
                            res_next.status = ST_EMPTY;
                        else
                        begin
                            res_strobe_next = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                    OP_READ_W, OP_WRITE_W:
                    begin
                        if (!src_ok || !dst_ok)
                        begin
                            res_next.status = ST_BAD_ID;
                            if (is_read)
                                res_next.weight_out = '1;
                        end
                        else if (!(head_rd < atot_reg))
                        begin
                            res_next.status = ST_NOT_FND;
                            if (is_read)
                                res_next.weight_out = '1;
                        end
                        else
                        begin
                            res_strobe_next = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                    OP_READ_V:
                    begin
                        if (!src_ok)
                            res_next.status = ST_BAD_ID;
                        else
                            res_next.payload_out = pay_q;
                    end
                    default:
                    begin
                        res_strobe_next = 1'b0;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
                // The arc at idx_reg is read this cycle; examine it next.
                state_next = S_EXAM;
            S_DONE:
                state_next = S_IDLE;
            S_EXAM:
            begin
                // One link of the chain per pass through S_WALK and S_EXAM.
                if (cur_reg.operation == OP_LIST)
                begin
                    res_strobe_next = 1'b1;
                    res_next.neighbor_id = tgt_q;
                    res_next.last = walk_end;
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = link_q;
                    state_next = walk_end ? S_IDLE : S_WALK;
                end
                else if (tgt_q == cur_reg.to_vertex)
                begin
                    res_strobe_next = 1'b1;
                    if (is_read)
                        res_next.weight_out = wgt_q;
                    else
                    begin
                        wgt_we   = 1'b1;
                        wgt_addr = idx_reg[AidW-1:0];
                    end
                    state_next = S_IDLE;
                end
                else if (chain_end)
                begin
                    res_strobe_next = 1'b1;
                    res_next.status = ST_NOT_FND;
                    if (is_read)
                        res_next.weight_out = '1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = link_q;
                    state_next = S_WALK;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        head_q <= head_mem[cur_reg.from_vertex];
        pay_q  <= pay_mem[cur_reg.from_vertex];
        tgt_q  <= tgt_mem[idx_reg[AidW-1:0]];
        wgt_q  <= wgt_mem[idx_reg[AidW-1:0]];
        link_q <= link_mem[idx_reg[AidW-1:0]];
        if (pay_we)
            pay_mem[vtot_reg[VidW-1:0]] <= cur_reg.vertex_payload;
        if (arc_we)
        begin
            tgt_mem[atot_reg[AidW-1:0]]  <= cur_reg.to_vertex;
            link_mem[atot_reg[AidW-1:0]] <= head_rd;
        end
        if (wgt_we)
            wgt_mem[wgt_addr] <= cur_reg.arc_weight;
        if (head_we)
            head_mem[cur_reg.from_vertex] <= atot_reg;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vtot_reg       <= '0;
            atot_reg       <= '0;
            head_vld_reg   <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vtot_reg       <= vtot_next;
            atot_reg       <= atot_next;
            head_vld_reg   <= head_vld_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;
endmodule

>>> src/forward_star_graph_store_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// command   | start, busy, cmd               | taken when start && !busy
// result    | result_strobe, result          | one cycle, cannot be held off
// config    | cfg_write, cfg_index, cfg_data | written when cfg_write is high
// A command steps through the head and read states; list, read weight and write
// weight add a walk and an examine state per arc link, set by the registered arc read.
// Reset clears the counts and the head valid bits at once; no clearing pass.
// A two-entry command queue sits between intake and the engine; busy is its full flag.
module forward_star_graph_store_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fsg_pkg::cmd_t             cmd,
    output logic                      result_strobe,
    output fsg_pkg::result_t          result,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [fsg_pkg::AcntW-1:0] cfg_data
);
    import fsg_pkg::*;

    logic [VcntW-1:0] vlim_reg;
    logic [AcntW-1:0] alim_reg;
    logic q_full, q_ne, pop, eng_idle;
    cmd_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlim_reg <= VcntW'(MaxVertices);
            alim_reg <= AcntW'(MaxArcs);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERTEX_LIMIT: vlim_reg <= cfg_data[VcntW-1:0];
                REG_ARC_LIMIT:    alim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = q_full;

    fsg_cmd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(start && !q_full), .push_data(cmd),
        .pop(pop), .full(q_full), .not_empty(q_ne), .head(q_head)
    );

    fsg_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(pop),
        .vlim((vlim_reg > VcntW'(MaxVertices)) ? VcntW'(MaxVertices) : vlim_reg),
        .alim((alim_reg > AcntW'(MaxArcs)) ? AcntW'(MaxArcs) : alim_reg),
        .res_strobe(result_strobe), .res(result), .idle(eng_idle)
    );

`include "forward_star_graph_store_unit_assert.svh"
    `FSG_ASSERT_NEXT(a_pop_busy, pop, !eng_idle)
    `FSG_ASSERT_IMPL(a_total_range, result_strobe, result.vertex_total <= VcntW'(MaxVertices))
    `FSG_ASSERT_IMPL(a_strobe_notidle, result_strobe, !eng_idle)
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import fsg_pkg::*;

    class graph_scoreboard;
        logic [AidW:0]         head_q [MaxVertices];
        logic [VidW-1:0]       target_q [MaxArcs];
        logic [WeightW-1:0]    weight_q [MaxArcs];
        logic [AidW:0]         link_q [MaxArcs];
        logic [PayloadW-1:0]   payload_q [MaxVertices];
        int unsigned           vertex_count;
        int unsigned           arc_total;
        int unsigned           vertex_cap;
        int unsigned           arc_cap;
        result_t               pending[$];
        int                    mismatches;
        int                    results_seen;
        int                    lists_seen;

        function new();
            for (int i = 0; i < MaxArcs; i++)
            begin
                target_q[i] = '0;
                weight_q[i] = '0;
                link_q[i] = '0;
            end
            for (int i = 0; i < MaxVertices; i++)
                payload_q[i] = '0;
            wipe();
            vertex_cap = 32;
            arc_cap = 64;
            mismatches = 0;
            results_seen = 0;
            lists_seen = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < MaxVertices; i++)
                head_q[i] = (AidW+1)'(MaxArcs);
            vertex_count = 0;
            arc_total = 0;
        endfunction

        function void set_limit(logic idx, logic [AcntW-1:0] val);
            if (idx == REG_VERTEX_LIMIT)
                vertex_cap = val & 63;
            else
                arc_cap = val;
        endfunction

        function void push(logic [2:0] st, logic [VidW-1:0] nb, logic [WeightW-1:0] w,
                           logic [PayloadW-1:0] pay, logic [VidW-1:0] nid, bit fin);
            result_t r;
            r.status = st;
            r.neighbor_id = nb;
            r.weight_out = w;
            r.payload_out = pay;
            r.new_vertex_id = nid;
            r.vertex_total = VcntW'(vertex_count);
            r.last = fin;
            pending.push_back(r);
        endfunction

        function int unsigned locate_arc(int unsigned src, int unsigned dst);
            int unsigned idx;
            int unsigned steps;
            idx = head_q[src];
            steps = 0;
            while (idx < arc_total && steps < MaxArcs)
            begin
                if (target_q[idx] == dst)
                    return idx;
                idx = link_q[idx];
                steps++;
            end
            return MaxArcs;
        endfunction

        function void note_command(cmd_t c);
            int unsigned vlim;
            int unsigned alim;
            int unsigned idx;
            int unsigned nxt;
            int unsigned k;
            bit src_ok;
            bit ids_ok;
            vlim = vertex_cap > MaxVertices ? MaxVertices : vertex_cap;
            alim = arc_cap > MaxArcs ? MaxArcs : arc_cap;
            src_ok = c.from_vertex < vertex_count;
            ids_ok = src_ok && (c.to_vertex < vertex_count);
            case (c.operation)
                OP_CLEAR:
                begin
                    wipe();
                    push(ST_OK, 0, 0, 0, 0, 1);
                end
                OP_ADD_V:
                    if (vertex_count >= vlim)
                        push(ST_FULL, 0, 0, 0, 0, 1);
                    else
                    begin
                        idx = vertex_count;
                        payload_q[idx] = c.vertex_payload;
                        head_q[idx] = (AidW+1)'(MaxArcs);
                        vertex_count++;
                        push(ST_OK, 0, 0, 0, VidW'(idx), 1);
                    end
                OP_ADD_A:
                    if (arc_total >= alim)
                        push(ST_FULL, 0, 0, 0, 0, 1);
                    else if (!ids_ok)
                        push(ST_BAD_ID, 0, 0, 0, 0, 1);
                    else
                    begin
                        idx = arc_total;
                        target_q[idx] = c.to_vertex;
                        weight_q[idx] = c.arc_weight;
                        link_q[idx] = head_q[c.from_vertex];
                        head_q[c.from_vertex] = (AidW+1)'(idx);
                        arc_total++;
                        push(ST_OK, 0, 0, 0, 0, 1);
                    end
                OP_LIST:
                    if (!src_ok)
                        push(ST_BAD_ID, 0, 0, 0, 0, 1);
                    else if (head_q[c.from_vertex] >= arc_total)
                        push(ST_EMPTY, 0, 0, 0, 0, 1);
                    else
                    begin
                        lists_seen++;
                        idx = head_q[c.from_vertex];
                        k = 0;
                        while (idx < arc_total && k < ResultCap)
                        begin
                            nxt = link_q[idx];
                            push(ST_OK, target_q[idx], 0, 0, 0,
                                 !(nxt < arc_total) || k + 1 >= ResultCap);
                            k++;
                            idx = nxt;
                        end
                    end
                OP_READ_W:
                    if (!ids_ok)
                        push(ST_BAD_ID, 0, '1, 0, 0, 1);
                    else
                    begin
                        idx = locate_arc(c.from_vertex, c.to_vertex);
                        if (idx == MaxArcs)
                            push(ST_NOT_FND, 0, '1, 0, 0, 1);
                        else
                            push(ST_OK, 0, weight_q[idx], 0, 0, 1);
                    end
                OP_WRITE_W:
                    if (!ids_ok)
                        push(ST_BAD_ID, 0, 0, 0, 0, 1);
                    else
                    begin
                        idx = locate_arc(c.from_vertex, c.to_vertex);
                        if (idx == MaxArcs)
                            push(ST_NOT_FND, 0, 0, 0, 0, 1);
                        else
                        begin
                            weight_q[idx] = c.arc_weight;
                            push(ST_OK, 0, 0, 0, 0, 1);
                        end
                    end
                OP_READ_V:
                    if (!src_ok)
                        push(ST_BAD_ID, 0, 0, 0, 0, 1);
                    else
                        push(ST_OK, 0, 0, payload_q[c.from_vertex], 0, 1);
                default:
                    ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             result_strobe;
    result_t          result;
    logic             cfg_write;
    logic             cfg_index;
    logic [AcntW-1:0] cfg_data;

    graph_scoreboard board;
    int               gap_pct;
    int               items_sent;

    forward_star_graph_store_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            board.check_result(result);
        if (rst_n && start && !busy)
            board.note_command(cmd);
    end

    // One command beat; start stays high across back-to-back beats.
    // Busy only moves at a rising edge, so its value at the falling edge
    // decides whether the next rising edge takes the beat.
    task automatic send_command(cmd_t c);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic go_idle();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        // Let the engine drain.
        repeat (200) @(negedge clk);
    endtask

    task automatic write_limit(logic idx, logic [AcntW-1:0] val);
        go_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_limit(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic cmd_t make_cmd(logic [2:0] op, int src, int dst);
        cmd_t c;
        c.operation = op;
        c.from_vertex = VidW'(src);
        c.to_vertex = VidW'(dst);
        c.arc_weight = WeightW'($urandom);
        c.vertex_payload = $urandom;
        return c;
    endfunction

    // Mostly valid ids with some out-of-range ones.
    function automatic int pick_id();
        if (board.vertex_count > 0 && $urandom_range(9) != 0)
            return $urandom_range(board.vertex_count - 1);
        return $urandom_range(31);
    endfunction

    task automatic random_phase(int count);
        int roll;
        cmd_t c;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                c = make_cmd(OP_CLEAR, $urandom_range(31), $urandom_range(31));
            else if (roll < 4)
                c = make_cmd(3'd7, $urandom_range(31), $urandom_range(31));
            else if (roll < 22)
                c = make_cmd(OP_ADD_V, $urandom_range(31), $urandom_range(31));
            else if (roll < 50)
                c = make_cmd(OP_ADD_A, pick_id(), pick_id());
            else if (roll < 65)
                c = make_cmd(OP_LIST, pick_id(), pick_id());
            else if (roll < 78)
                c = make_cmd(OP_READ_W, pick_id(), pick_id());
            else if (roll < 90)
                c = make_cmd(OP_WRITE_W, pick_id(), pick_id());
            else
                c = make_cmd(OP_READ_V, pick_id(), pick_id());
            if ($urandom_range(15) == 0)
            begin
                c.arc_weight = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                c.vertex_payload = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            end
            send_command(c);
        end
    endtask

    initial
    begin
        cmd_t c;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_write = 1'b0;
        cfg_index = REG_VERTEX_LIMIT;
        cfg_data = '0;
        gap_pct = 0;
        items_sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-store errors, then a small graph.
        send_command(make_cmd(OP_LIST, 0, 0));
        send_command(make_cmd(OP_READ_V, 31, 0));
        send_command(make_cmd(OP_ADD_A, 0, 0));
        send_command(make_cmd(3'd7, 0, 0));
        c = make_cmd(OP_ADD_V, 0, 0);
        c.vertex_payload = 32'hFFFF_FFFF;
        send_command(c);
        c.vertex_payload = 32'h0;
        send_command(c);
        send_command(make_cmd(OP_ADD_V, 0, 0));
        send_command(make_cmd(OP_LIST, 1, 0));
        c = make_cmd(OP_ADD_A, 0, 1);
        c.arc_weight = 16'hFFFF;
        send_command(c);
        c = make_cmd(OP_ADD_A, 0, 2);
        c.arc_weight = 16'h0000;
        send_command(c);
        send_command(make_cmd(OP_ADD_A, 0, 1));
        send_command(make_cmd(OP_ADD_A, 0, 3));
        send_command(make_cmd(OP_LIST, 0, 0));
        send_command(make_cmd(OP_READ_W, 0, 1));
        send_command(make_cmd(OP_READ_W, 0, 0));
        send_command(make_cmd(OP_WRITE_W, 0, 1));
        send_command(make_cmd(OP_WRITE_W, 2, 1));
        send_command(make_cmd(OP_READ_W, 0, 1));
        send_command(make_cmd(OP_READ_V, 0, 0));
        send_command(make_cmd(OP_READ_V, 1, 0));
        send_command(make_cmd(OP_READ_V, 3, 0));
        send_command(make_cmd(OP_CLEAR, 0, 0));
        send_command(make_cmd(OP_LIST, 0, 0));

        // Limit extremes: zero, one, and out of range.
        write_limit(REG_VERTEX_LIMIT, 0);
        write_limit(REG_ARC_LIMIT, 0);
        send_command(make_cmd(OP_ADD_V, 0, 0));
        send_command(make_cmd(OP_ADD_A, 0, 0));
        write_limit(REG_VERTEX_LIMIT, 1);
        write_limit(REG_ARC_LIMIT, 1);
        gap_pct = 8;
        random_phase(60);
        write_limit(REG_VERTEX_LIMIT, 63);
        write_limit(REG_ARC_LIMIT, 127);
        random_phase(120);

        // Fill one vertex with every arc for a full-length list.
        go_idle();
        send_command(make_cmd(OP_CLEAR, 0, 0));
        send_command(make_cmd(OP_ADD_V, 0, 0));
        send_command(make_cmd(OP_ADD_V, 0, 0));
        repeat (65)
            send_command(make_cmd(OP_ADD_A, 0, $urandom_range(1)));
        send_command(make_cmd(OP_LIST, 0, 0));
        send_command(make_cmd(OP_READ_W, 0, 1));

        gap_pct = 49;
        write_limit(REG_VERTEX_LIMIT, 5);
        write_limit(REG_ARC_LIMIT, 20);
        send_command(make_cmd(OP_CLEAR, 0, 0));
        random_phase(120);
        gap_pct = 0;
        write_limit(REG_VERTEX_LIMIT, 32);
        write_limit(REG_ARC_LIMIT, 64);
        send_command(make_cmd(OP_CLEAR, 0, 0));
        random_phase(130);

        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        $display("Sent %0d commands, checked %0d result beats, %0d non-empty lists.",
                 items_sent, board.results_seen, board.lists_seen);
        $display("Limits swept from zero to out of range; %0d mismatches.", board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/fsg_pkg.sv
src/fsg_cmd_queue.sv
src/fsg_engine.sv
src/forward_star_graph_store_unit.sv
tb/tb.sv
